// ===== rtl/sorted_record_table_unit_assert.svh =====
// Assertion macros for the sorted record table.
// Every macro samples on i_clk and is switched off while i_rst_n is low.
`ifndef SORTED_RECORD_TABLE_UNIT_ASSERT_SVH
`define SORTED_RECORD_TABLE_UNIT_ASSERT_SVH

// Check that a condition holds in the same cycle as its trigger.
`define SRT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define SRT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/srt_pkg.sv =====
// Shared types and constants for the sorted record table.
// Used by the storage cell and by the top level; depends on nothing.
package srt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ID_W        = 24;
    localparam int SCORE_W     = 10;
    localparam int POS_W       = 6;
    localparam int COUNT_OUT_W = 7;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
    } t_rec;

    // command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_cmd;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_FIND   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_OK   = 2'd0,
        STS_FULL = 2'd1,
        STS_MISS = 2'd2
    } t_status;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

endpackage

// ===== rtl/srt_cell.sv =====
// One slot of the record chain: holds a record and shifts it to or from
// its neighbors on insert and delete. Depends on srt_pkg.
module srt_cell import srt_pkg::*; (
    input  logic               i_clk,
    input  t_cell_cmd          i_cmd,
    input  logic               i_occ,
    input  logic [ID_W-1:0]    i_key_id,
    input  logic [SCORE_W-1:0] i_key_score,
    input  t_rec               i_prev_rec,
    input  logic               i_prev_after,
    input  logic               i_prev_delpfx,
    input  logic               i_prev_idm,
    input  t_rec               i_next_rec,
    output t_rec               o_rec,
    output logic               o_after,
    output logic               o_delpfx,
    output logic               o_idm,
    output logic               o_first_id
);

    t_rec r_rec;
    t_rec n_rec;
    logic w_del_match;

    // empty slots count as holding an id larger than any key
    assign o_after     = !i_occ || (r_rec.id > i_key_id);
    assign w_del_match = i_occ && (r_rec.score == i_key_score);
    assign o_delpfx    = i_prev_delpfx || w_del_match;
    assign o_idm       = i_occ && (r_rec.id == i_key_id);
    assign o_first_id  = o_idm && !i_prev_idm;
    assign o_rec       = r_rec;

    always_comb begin
        n_rec = r_rec;
        if (i_cmd.ins) begin
            if (o_after && !i_prev_after) begin
                n_rec.id    = i_key_id;
                n_rec.score = i_key_score;
            end else if (o_after) begin
                n_rec = i_prev_rec;
            end
        end else if (i_cmd.del && o_delpfx) begin
            // close the gap left by the first match
            n_rec = i_next_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rec <= n_rec;
    end

endmodule

// ===== rtl/sorted_record_table_unit.sv =====
// Sorted record table: up to TABLE_DEPTH (id, score) records kept in ascending id order
// in a chain of cells. For insert, find and unused codes the request is first registered,
// then the cells compare every slot at once and the result is registered.
// Delete-by-score drops the first matching record per cycle and shifts the rest down by
// one, until no match is left; then the result is registered. A new request is
// taken once the previous result has been taken or is taken in the same cycle.
// Depends on srt_pkg, srt_cell and sorted_record_table_unit_assert.svh.
`include "sorted_record_table_unit_assert.svh"

module sorted_record_table_unit import srt_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_operation,
    input  logic [ID_W-1:0]        i_entry_id,
    input  logic [SCORE_W-1:0]     i_entry_score,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [1:0]             o_status,
    output logic [POS_W-1:0]       o_found_position,
    output logic [SCORE_W-1:0]     o_found_score,
    output logic [COUNT_OUT_W-1:0] o_removed_count,
    output logic [COUNT_OUT_W-1:0] o_entry_count
);

    t_state                 r_state, n_state;
    t_op                    r_op, n_op;
    logic [ID_W-1:0]        r_key_id, n_key_id;
    logic [SCORE_W-1:0]     r_key_score, n_key_score;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [CNT_W-1:0]       r_removed, n_removed;
    logic                   r_ovalid, n_ovalid;
    t_status                r_status, n_status;
    logic [POS_W-1:0]       r_pos, n_pos;
    logic [SCORE_W-1:0]     r_fscore, n_fscore;
    logic [COUNT_OUT_W-1:0] r_rem_out, n_rem_out;
    logic [COUNT_OUT_W-1:0] r_cnt_out, n_cnt_out;

    t_cell_cmd              w_cmd;
    logic                   w_accept;
    logic                   w_finish;
    logic [TABLE_DEPTH-1:0] w_occ, w_after, w_delpfx, w_idm, w_first;
    t_rec                   w_rec [TABLE_DEPTH];
    logic                   w_any_first;
    logic [POS_W-1:0]       w_find_pos;
    logic [SCORE_W-1:0]     w_find_score;

    assign o_ready  = (r_state == S_IDLE) && (!r_ovalid || i_ready);
    assign w_accept = i_valid && o_ready;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        assign w_occ[g] = r_count > CNT_W'(g);
        if (g == 0) begin : g_head
            srt_cell u_cell (
                .i_clk         (i_clk),
                .i_cmd         (w_cmd),
                .i_occ         (w_occ[g]),
                .i_key_id      (r_key_id),
                .i_key_score   (r_key_score),
                .i_prev_rec    (w_rec[g]),
                .i_prev_after  (1'b0),
                .i_prev_delpfx (1'b0),
                .i_prev_idm    (1'b0),
                .i_next_rec    (w_rec[(g + 1) % TABLE_DEPTH]),
                .o_rec         (w_rec[g]),
                .o_after       (w_after[g]),
                .o_delpfx      (w_delpfx[g]),
                .o_idm         (w_idm[g]),
                .o_first_id    (w_first[g])
            );
        end else if (g == TABLE_DEPTH - 1) begin : g_tail
            srt_cell u_cell (
                .i_clk         (i_clk),
                .i_cmd         (w_cmd),
                .i_occ         (w_occ[g]),
                .i_key_id      (r_key_id),
                .i_key_score   (r_key_score),
                .i_prev_rec    (w_rec[g - 1]),
                .i_prev_after  (w_after[g - 1]),
                .i_prev_delpfx (w_delpfx[g - 1]),
                .i_prev_idm    (w_idm[g - 1]),
                .i_next_rec    (w_rec[g]),
                .o_rec         (w_rec[g]),
                .o_after       (w_after[g]),
                .o_delpfx      (w_delpfx[g]),
                .o_idm         (w_idm[g]),
                .o_first_id    (w_first[g])
            );
        end else begin : g_mid
            srt_cell u_cell (
                .i_clk         (i_clk),
                .i_cmd         (w_cmd),
                .i_occ         (w_occ[g]),
                .i_key_id      (r_key_id),
                .i_key_score   (r_key_score),
                .i_prev_rec    (w_rec[g - 1]),
                .i_prev_after  (w_after[g - 1]),
                .i_prev_delpfx (w_delpfx[g - 1]),
                .i_prev_idm    (w_idm[g - 1]),
                .i_next_rec    (w_rec[g + 1]),
                .o_rec         (w_rec[g]),
                .o_after       (w_after[g]),
                .o_delpfx      (w_delpfx[g]),
                .o_idm         (w_idm[g]),
                .o_first_id    (w_first[g])
            );
        end
    end

    // at most one cell flags the first id match, so OR-select is enough
    always_comb begin
        w_find_pos   = '0;
        w_find_score = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (w_first[i]) begin
                w_find_pos   = w_find_pos | POS_W'(i);
                w_find_score = w_find_score | w_rec[i].score;
            end
        end
    end
    assign w_any_first = |w_first;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key_id    = r_key_id;
        n_key_score = r_key_score;
        n_count     = r_count;
        n_removed   = r_removed;
        n_status    = r_status;
        n_pos       = r_pos;
        n_fscore    = r_fscore;
        n_rem_out   = r_rem_out;
        n_cnt_out   = r_cnt_out;
        w_cmd       = '0;
        w_finish    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op        = t_op'(i_operation);
                    n_key_id    = i_entry_id;
                    n_key_score = i_entry_score;
                    n_removed   = '0;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status  = STS_OK;
                n_pos     = '0;
                n_fscore  = '0;
                n_rem_out = '0;
                unique case (r_op)
                    OP_INSERT: begin
                        w_finish = 1'b1;
                        if (r_count == CNT_W'(TABLE_DEPTH)) begin
                            n_status = STS_FULL;
                        end else begin
                            w_cmd.ins = 1'b1;
                            n_count   = r_count + 1'b1;
                        end
                    end
                    OP_DELETE: begin
                        // drop one match per cycle until none is left
                        if (w_delpfx[TABLE_DEPTH-1]) begin
                            w_cmd.del = 1'b1;
                            n_count   = r_count - 1'b1;
                            n_removed = r_removed + 1'b1;
                        end else begin
                            w_finish  = 1'b1;
                            n_rem_out = COUNT_OUT_W'(r_removed);
                        end
                    end
                    OP_FIND: begin
                        w_finish = 1'b1;
                        if (w_any_first) begin
                            n_pos    = w_find_pos;
                            n_fscore = w_find_score;
                        end else begin
                            n_status = STS_MISS;
                        end
                    end
                    default: begin
                        w_finish = 1'b1;
                    end
                endcase
                if (w_finish) begin
                    n_cnt_out = COUNT_OUT_W'(n_count);
                    n_state   = S_IDLE;
                end else begin
                    n_status  = r_status;
                    n_pos     = r_pos;
                    n_fscore  = r_fscore;
                    n_rem_out = r_rem_out;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_finish) begin
            n_ovalid = 1'b1;
        end else if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_key_id    <= n_key_id;
        r_key_score <= n_key_score;
        r_removed   <= n_removed;
        r_status    <= n_status;
        r_pos       <= n_pos;
        r_fscore    <= n_fscore;
        r_rem_out   <= n_rem_out;
        r_cnt_out   <= n_cnt_out;
    end

    assign o_valid          = r_ovalid;
    assign o_status         = r_status;
    assign o_found_position = r_pos;
    assign o_found_score    = r_fscore;
    assign o_removed_count  = r_rem_out;
    assign o_entry_count    = r_cnt_out;

    `SRT_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(TABLE_DEPTH),
        "record count above table depth")
    `SRT_ASSERT_NOW(a_first_unique, r_state == S_EXEC && r_op == OP_FIND,
        $onehot0(w_first), "more than one first id match")
    `SRT_ASSERT_NEXT(a_insert_grows,
        r_state == S_EXEC && r_op == OP_INSERT && r_count != CNT_W'(TABLE_DEPTH),
        r_count == $past(r_count) + 1'b1 && r_ovalid, "insert did not add a record")
    `SRT_ASSERT_NEXT(a_delete_step, w_cmd.del,
        r_removed == $past(r_removed) + 1'b1 && r_count == $past(r_count) - 1'b1,
        "delete step lost track of counts")

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking bench for sorted_record_table_unit: a directed table, then random traffic.
// Keeps its own ordered record list to work out every reply; needs srt_pkg and the RTL.
module tb import srt_pkg::*; ();

    localparam int CYCLE_LIMIT = 700000;
    localparam int SETTLE_CYCLES = 80;     // covers a delete that empties a full table
    localparam logic [ID_W-1:0] ID_TOP = '1;
    localparam logic [SCORE_W-1:0] SCORE_TOP = '1;

    typedef struct packed {
        t_status                status;
        logic [POS_W-1:0]       pos;
        logic [SCORE_W-1:0]     score;
        logic [COUNT_OUT_W-1:0] removed;
        logic [COUNT_OUT_W-1:0] count;
    } t_reply;

    typedef struct packed {
        t_op                op;
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
        logic               typed;
        t_reply             want;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic [1:0]             i_operation = '0;
    logic [ID_W-1:0]        i_entry_id = '0;
    logic [SCORE_W-1:0]     i_entry_score = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic [1:0]             o_status;
    logic [POS_W-1:0]       o_found_position;
    logic [SCORE_W-1:0]     o_found_score;
    logic [COUNT_OUT_W-1:0] o_removed_count;
    logic [COUNT_OUT_W-1:0] o_entry_count;

    t_rec   held_records[$];
    t_reply owed_replies[$];
    int     bad_fields = 0;
    int     cycle_count = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    bit     draining = 1'b0;
    int     full_tries_left = 4;
    int     low_mark = 0;

    sorted_record_table_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_operation      (i_operation),
        .i_entry_id       (i_entry_id),
        .i_entry_score    (i_entry_score),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_found_score    (o_found_score),
        .o_removed_count  (o_removed_count),
        .o_entry_count    (o_entry_count)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // Apply one request to the record list and return the reply it earns.
    function automatic t_reply table_apply(t_op op, logic [ID_W-1:0] id,
                                           logic [SCORE_W-1:0] sc);
        t_reply r;
        t_rec   rec;
        t_rec   kept[$];
        int     at;
        int     i;
        r = '0;
        r.status = STS_OK;
        case (op)
            OP_INSERT: begin
                if (held_records.size() >= TABLE_DEPTH) begin
                    r.status = STS_FULL;
                end else begin
                    // land after every record with an equal id
                    at = 0;
                    while (at < held_records.size() && held_records[at].id <= id)
                        at++;
                    rec.id = id;
                    rec.score = sc;
                    held_records.insert(at, rec);
                end
            end
            OP_DELETE: begin
                for (i = 0; i < held_records.size(); i++) begin
                    if (held_records[i].score == sc)
                        r.removed = r.removed + 1'b1;
                    else
                        kept.push_back(held_records[i]);
                end
                held_records = kept;
            end
            OP_FIND: begin
                r.status = STS_MISS;
                for (i = 0; i < held_records.size(); i++) begin
                    if (held_records[i].id == id) begin
                        r.status = STS_OK;
                        r.pos = POS_W'(i);
                        r.score = held_records[i].score;
                        break;
                    end
                    if (held_records[i].id > id)
                        break;
                end
            end
            default: ;
        endcase
        r.count = COUNT_OUT_W'(held_records.size());
        return r;
    endfunction

    function automatic t_row dir_row(t_op op, logic [ID_W-1:0] id, logic [SCORE_W-1:0] sc,
                                     logic typed, t_status st, int cnt);
        t_row row_v;
        row_v = '0;
        row_v.op = op;
        row_v.id = id;
        row_v.score = sc;
        row_v.typed = typed;
        row_v.want.status = st;
        row_v.want.count = COUNT_OUT_W'(cnt);
        return row_v;
    endfunction

    task automatic flag_reply_field(string what, int got, int want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
        bad_fields++;
    endtask

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_request(t_op op, logic [ID_W-1:0] id, logic [SCORE_W-1:0] sc,
                                logic typed, t_reply want);
        bit     taken;
        t_reply model_reply;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_entry_id <= id;
        i_entry_score <= sc;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = o_ready;
            if (!taken)
                @(negedge i_clk);
        end
        model_reply = table_apply(op, id, sc);
        owed_replies.push_back(typed ? want : model_reply);
        @(negedge i_clk);
    endtask

    // Alternate filling to full and draining by score so every depth gets visited.
    task automatic run_random(int n);
        int                 k;
        int                 size;
        int                 roll;
        t_op                op;
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] sc;
        for (k = 0; k < n; k++) begin
            size = held_records.size();
            if (!draining && size == TABLE_DEPTH && full_tries_left == 0) begin
                draining = 1'b1;
                low_mark = $urandom_range(8);
            end else if (draining && size <= low_mark) begin
                draining = 1'b0;
                full_tries_left = $urandom_range(8, 3);
            end
            roll = $urandom_range(99);
            if (draining) begin
                if (roll < 50) op = OP_DELETE;
                else if (roll < 80) op = OP_FIND;
                else if (roll < 95) op = OP_INSERT;
                else op = OP_NONE;
            end else begin
                if (roll < 60) op = OP_INSERT;
                else if (roll < 90) op = OP_FIND;
                else if (roll < 95) op = OP_DELETE;
                else op = OP_NONE;
            end
            if (op == OP_INSERT && size == TABLE_DEPTH && full_tries_left > 0)
                full_tries_left--;

            roll = $urandom_range(99);
            if (roll < 40 && size > 0) begin
                id = held_records[$urandom_range(size - 1)].id;
                if ($urandom_range(9) == 0)
                    id = id + 1'b1;
            end else if (roll < 70) begin
                id = ID_W'($urandom_range(15));
            end else if (roll < 90) begin
                id = ID_W'($urandom);
            end else begin
                id = $urandom_range(1) ? ID_TOP : '0;
            end

            roll = $urandom_range(99);
            if (op == OP_DELETE && size > 0 && roll < 70)
                sc = held_records[$urandom_range(size - 1)].score;
            else if (roll < 85)
                sc = SCORE_W'($urandom_range(7));
            else
                sc = SCORE_W'($urandom);

            send_request(op, id, sc, 1'b0, '0);
        end
    endtask

    always @(negedge i_clk)
        i_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge i_clk) begin : reply_check
        t_reply want;
        if (i_rst_n && o_valid && i_ready) begin
            if (owed_replies.size() == 0) begin
                flag_reply_field("reply with nothing owed, status", o_status, 0);
            end else begin
                want = owed_replies.pop_front();
                if (o_status != want.status)
                    flag_reply_field("status", o_status, want.status);
                if (o_found_position != want.pos)
                    flag_reply_field("found_position", o_found_position, want.pos);
                if (o_found_score != want.score)
                    flag_reply_field("found_score", o_found_score, want.score);
                if (o_removed_count != want.removed)
                    flag_reply_field("removed_count", o_removed_count, want.removed);
                if (o_entry_count != want.count)
                    flag_reply_field("entry_count", o_entry_count, want.count);
            end
        end
    end

    initial begin : stimulus
        t_row plan[$];
        int   r;
        send_idle_pct = 34;
        recv_idle_pct = 52;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty table, unused code, and the extremes of id and score
        plan.push_back(dir_row(OP_FIND,   '0,         '0,        1'b1, STS_MISS, 0));
        plan.push_back(dir_row(OP_NONE,   ID_TOP,     SCORE_TOP, 1'b1, STS_OK,   0));
        plan.push_back(dir_row(OP_DELETE, '0,         '0,        1'b1, STS_OK,   0));
        plan.push_back(dir_row(OP_INSERT, ID_TOP,     SCORE_TOP, 1'b1, STS_OK,   1));
        plan.push_back(dir_row(OP_INSERT, '0,         '0,        1'b1, STS_OK,   2));
        plan.push_back(dir_row(OP_INSERT, ID_TOP,     10'h001,   1'b1, STS_OK,   3));
        plan.push_back(dir_row(OP_INSERT, 24'h800000, 10'h200,   1'b0, STS_OK,   0));
        plan.push_back(dir_row(OP_INSERT, 24'h7FFFFF, 10'h1FF,   1'b0, STS_OK,   0));
        plan.push_back(dir_row(OP_FIND,   ID_TOP,     '0,        1'b0, STS_OK,   0));
        plan.push_back(dir_row(OP_FIND,   '0,         '0,        1'b0, STS_OK,   0));
        plan.push_back(dir_row(OP_FIND,   24'h7FFFFE, '0,        1'b0, STS_OK,   0));
        plan.push_back(dir_row(OP_INSERT, '0,         10'h001,   1'b0, STS_OK,   0));
        plan.push_back(dir_row(OP_FIND,   '0,         '0,        1'b0, STS_OK,   0));
        plan.push_back(dir_row(OP_NONE,   24'h123456, 10'h155,   1'b0, STS_OK,   0));
        plan.push_back(dir_row(OP_DELETE, '0,         10'h001,   1'b0, STS_OK,   0));
        plan.push_back(dir_row(OP_DELETE, '0,         10'h007,   1'b0, STS_OK,   0));
        plan.push_back(dir_row(OP_FIND,   24'h123456, '0,        1'b0, STS_OK,   0));
        plan.push_back(dir_row(OP_DELETE, '0,         SCORE_TOP, 1'b0, STS_OK,   0));
        plan.push_back(dir_row(OP_DELETE, '0,         '0,        1'b0, STS_OK,   0));
        plan.push_back(dir_row(OP_DELETE, '0,         10'h1FF,   1'b0, STS_OK,   0));
        plan.push_back(dir_row(OP_DELETE, '0,         10'h200,   1'b0, STS_OK,   0));
        plan.push_back(dir_row(OP_INSERT, 24'h555555, 10'h155,   1'b0, STS_OK,   0));
        plan.push_back(dir_row(OP_INSERT, 24'hAAAAAA, 10'h2AA,   1'b0, STS_OK,   0));
        plan.push_back(dir_row(OP_FIND,   24'hAAAAAA, '0,        1'b0, STS_OK,   0));
        plan.push_back(dir_row(OP_DELETE, '0,         10'h155,   1'b0, STS_OK,   0));

        for (r = 0; r < plan.size(); r++)
            send_request(plan[r].op, plan[r].id, plan[r].score, plan[r].typed, plan[r].want);

        run_random(510);
        send_idle_pct = 52;
        recv_idle_pct = 34;
        run_random(510);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(510);

        i_valid <= 1'b0;
        while (owed_replies.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (bad_fields == 0 && owed_replies.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
